// File: rtl/meq_pkg.sv
package meq_pkg;

	typedef logic [127:0] q128_t;

	// Escape threshold on the upper word of the sum of squares (4.0 in Q4.124).
	localparam logic [63:0] EscapeHi = 64'h4000_0000_0000_0000;

	// Partial-product order for the 4x4 limb multiply, grouped by column.
	// Each entry is {column_end, i[1:0], j[1:0]}.
	localparam logic [4:0] MulSeq [16] = '{
		5'b1_00_00,
		5'b0_00_01, 5'b1_01_00,
		5'b0_00_10, 5'b0_01_01, 5'b1_10_00,
		5'b0_00_11, 5'b0_01_10, 5'b0_10_01, 5'b1_11_00,
		5'b0_01_11, 5'b0_10_10, 5'b1_11_01,
		5'b0_10_11, 5'b1_11_10,
		5'b1_11_11
	};

	function automatic q128_t neg128(input q128_t a);
		return ~a + 128'd1;
	endfunction

endpackage

// File: rtl/meq_mul.sv
module meq_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  meq_pkg::q128_t       a,
	input  meq_pkg::q128_t       b,
	output logic                 done,
	output meq_pkg::q128_t       product
);

	logic [127:0] x_q, y_q;
	logic [3:0]   n_q;
	logic         run_q;
	logic [63:0]  p_s1;
	logic         end_s1, vld_s1, last_s1;
	logic         fin_q, done_q;
	logic [71:0]  acc_q;
	logic [255:0] prod_q;
	logic [4:0]   seq;
	logic [31:0]  xl, yl;
	logic [71:0]  sum;

	assign seq = meq_pkg::MulSeq[n_q];
	assign xl  = x_q[32*seq[3:2] +: 32];
	assign yl  = y_q[32*seq[1:0] +: 32];
	assign sum = acc_q + {8'd0, p_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			n_q     <= '0;
			vld_s1  <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= vld_s1 && last_s1;
			vld_s1 <= run_q;
			if (start) begin
				run_q <= 1'b1;
				n_q   <= '0;
			end else if (run_q) begin
				n_q <= n_q + 4'd1;
				if (n_q == 4'd15) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= a;
			y_q   <= b;
			acc_q <= '0;
		end else begin
			if (vld_s1) begin
				if (end_s1) begin
					prod_q <= {sum[31:0], prod_q[255:32]};
					acc_q  <= {32'd0, sum[71:32]};
				end else begin
					acc_q <= sum;
				end
			end
			if (fin_q) begin
				prod_q <= {acc_q[31:0], prod_q[255:32]};
			end
		end
		p_s1    <= {32'd0, xl} * {32'd0, yl};
		end_s1  <= seq[4];
		last_s1 <= (n_q == 4'd15);
	end

	assign done    = done_q;
	assign product = prod_q[251:124];

endmodule

// File: rtl/mandelbrot_escape_q4_124.sv
// Escape-time test of the Mandelbrot set in signed Q4.124 fixed point.
// Each 128x128 product runs 16 partial products through one 32x32
// multiplier. An iteration is three products plus the escape test and the
// update. The result is ready once the point escapes after N full iterations
// or reaches the limit L; if L is zero no product is started and the
// sequencer goes straight to the result.
// Throughput: one point at a time; s_tready stays low until the result beat.
// Reset (arst_n low, asynchronous) idles the sequencer, drops m_tvalid, raises
// s_tready and sets iteration_limit to 256.
module mandelbrot_escape_q4_124 #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	// tdata: c_real_high[63:0], c_real_low[127:64], c_imag_high[191:128],
	// c_imag_low[255:192]
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,
	// tdata: iteration_count[23:0], colour_word[47:24]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,
	// tuser: in_set[0]
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	// Count mask; widths above 24 leave the full count visible.
	localparam logic [23:0] CountMask = (COUNT_WIDTH >= 24) ? 24'hFF_FFFF :
		24'((64'd1 << COUNT_WIDTH) - 64'd1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SR   = 3'd1;
	localparam logic [2:0] S_SI   = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_T    = 3'd4;
	localparam logic [2:0] S_UPD  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]     state_q;
	logic [23:0]    limit_q;
	logic [23:0]    cnt_q;
	logic           start_q;
	logic           in_set_q;
	meq_pkg::q128_t cr_q, ci_q, zr_q, zi_q, sr_q, si_q, t_q;
	meq_pkg::q128_t op_a_q, op_b_q;
	meq_pkg::q128_t zr_mag, zi_mag, prod, s_sum;
	meq_pkg::q128_t zr_next, zr_next_mag;
	logic           mul_done;
	logic [7:0]     cnt_lo;

	// The limit register is written on the access phase of an APB write with paddr[2] low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 24'd256;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			limit_q <= pwdata[23:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {8'd0, limit_q};

	assign zr_mag = zr_q[127] ? meq_pkg::neg128(zr_q) : zr_q;
	assign zi_mag = zi_q[127] ? meq_pkg::neg128(zi_q) : zi_q;
	assign s_sum  = sr_q + si_q;

	// Updated real part and its magnitude for the next squaring.
	assign zr_next     = sr_q - si_q + cr_q;
	assign zr_next_mag = zr_next[127] ? meq_pkg::neg128(zr_next) : zr_next;

	meq_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.a       (op_a_q),
		.b       (op_b_q),
		.done    (mul_done),
		.product (prod)
	);

	// Sequencer: square zr, square zi, test the sum, form zr*zi, update z.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (limit_q == 24'd0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_SR;
							start_q <= 1'b1;
						end
					end
				end
				S_SR: begin
					if (mul_done) begin
						state_q <= S_SI;
						start_q <= 1'b1;
					end
				end
				S_SI: begin
					if (mul_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!s_sum[127] && s_sum[127:64] >= meq_pkg::EscapeHi) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_T;
						start_q <= 1'b1;
					end
				end
				S_T: begin
					if (mul_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (cnt_q + 24'd1 == limit_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SR;
						start_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers follow the sequencer and carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cr_q     <= {s_tdata[63:0], s_tdata[127:64]};
				ci_q     <= {s_tdata[191:128], s_tdata[255:192]};
				zr_q     <= {s_tdata[63:0], s_tdata[127:64]};
				zi_q     <= {s_tdata[191:128], s_tdata[255:192]};
				cnt_q    <= 24'd0;
				in_set_q <= 1'b1;
				op_a_q   <= s_tdata[63] ? meq_pkg::neg128({s_tdata[63:0], s_tdata[127:64]}) :
					{s_tdata[63:0], s_tdata[127:64]};
				op_b_q   <= s_tdata[63] ? meq_pkg::neg128({s_tdata[63:0], s_tdata[127:64]}) :
					{s_tdata[63:0], s_tdata[127:64]};
			end
			S_SR: begin
				if (mul_done) begin
					sr_q   <= prod;
					op_a_q <= zi_mag;
					op_b_q <= zi_mag;
				end
			end
			S_SI: begin
				if (mul_done) begin
					si_q <= prod;
				end
			end
			S_CHK: begin
				if (!s_sum[127] && s_sum[127:64] >= meq_pkg::EscapeHi) begin
					in_set_q <= 1'b0;
				end
				op_a_q <= zr_mag;
				op_b_q <= zi_mag;
			end
			S_T: begin
				if (mul_done) begin
					t_q <= (zr_q[127] ^ zi_q[127]) ? meq_pkg::neg128(prod) : prod;
				end
			end
			S_UPD: begin
				zr_q   <= zr_next;
				zi_q   <= {t_q[126:0], 1'b0} + ci_q;
				cnt_q  <= cnt_q + 24'd1;
				// The next squaring works on the magnitude of the updated zr.
				op_a_q <= zr_next_mag;
				op_b_q <= zr_next_mag;
			end
			default: begin
			end
		endcase
	end

	assign cnt_lo = cnt_q[7:0];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tuser  = in_set_q;
	assign m_tdata  = {
		in_set_q ? 24'd0 : {cnt_lo, 7'd0, cnt_q[2:0], 6'd0},
		cnt_q & CountMask
	};

endmodule

// File: rtl/meq_check.sv
module meq_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second point while busy");

	a_result_excludes_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result is pending");

	a_in_set_no_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[47:24] == 24'd0)
		else $error("colour word nonzero for an in-set point");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind mandelbrot_escape_q4_124 meq_check u_meq_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
